FILE: sv/wpsd_pkg.sv
package wpsd_pkg;

	localparam int HEADER_BYTES = 44;

	localparam logic [5:0] POS_LAST  = 6'(HEADER_BYTES - 1);
	localparam logic [5:0] POS_RIFF  = 6'd3;
	localparam logic [5:0] POS_WAVE  = 6'd11;
	localparam logic [5:0] POS_FMT   = 6'd15;
	localparam logic [5:0] POS_FTAG  = 6'd21;
	localparam logic [5:0] POS_CHANS = 6'd23;
	localparam logic [5:0] POS_RATE  = 6'd27;
	localparam logic [5:0] POS_BITS  = 6'd35;
	localparam logic [5:0] POS_DATA  = 6'd39;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] RATE_FULL = 32'd22050;
	localparam logic [31:0] RATE_HALF = 32'd11025;
	localparam logic [15:0] FMT_PCM    = 16'd1;
	localparam logic [15:0] CHANS_MONO = 16'd1;
	localparam logic [15:0] BITS_EIGHT = 16'd8;
	localparam logic [15:0] BIAS_8BIT  = 16'h7F00;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  cnt;
		kind_t       kind;
		logic [15:0] sample;
		logic        half_rate;
		logic        eight_bit;
		logic        eod;
	} res_t;

endpackage

FILE: sv/wpsd_parse.sv
module wpsd_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic             cmd,
	input  logic [7:0]       data_byte,
	output wpsd_pkg::res_t   res
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [5:0]  pos_q, pos_d;
	logic        good_q, good_d;
	logic [31:0] fa_q, fa_d;
	logic        eight_q, eight_d;
	logic        half_q, half_d;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  hold_q, hold_d;
	logic        pend_q, pend_d;

	logic [31:0] fa_shift;
	logic [15:0] half16;
	logic [31:0] rem_dec;
	logic        eod;

	assign fa_shift = {data_byte, fa_q[31:8]};
	assign half16   = fa_shift[31:16];
	assign rem_dec  = rem_q - 32'd1;
	assign eod      = (rem_dec == 32'd0);

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		good_d  = good_q;
		fa_d    = fa_q;
		eight_d = eight_q;
		half_d  = half_q;
		rem_d   = rem_q;
		hold_d  = hold_q;
		pend_d  = pend_q;
		res     = '0;
		res.kind = wpsd_pkg::KIND_SAMPLE;
		if (cmd) begin
			phase_d = PH_HEADER;
			pos_d   = '0;
			good_d  = 1'b1;
			fa_d    = '0;
			eight_d = 1'b0;
			half_d  = 1'b0;
			rem_d   = '0;
			hold_d  = '0;
			pend_d  = 1'b0;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					fa_d  = fa_shift;
					pos_d = pos_q + 6'd1;
					case (pos_q)
						wpsd_pkg::POS_RIFF: begin
							if (fa_shift != wpsd_pkg::TAG_RIFF) good_d = 1'b0;
						end
						wpsd_pkg::POS_WAVE: begin
							if (fa_shift != wpsd_pkg::TAG_WAVE) good_d = 1'b0;
						end
						wpsd_pkg::POS_FMT: begin
							if (fa_shift != wpsd_pkg::TAG_FMT) good_d = 1'b0;
						end
						wpsd_pkg::POS_FTAG: begin
							if (half16 != wpsd_pkg::FMT_PCM) good_d = 1'b0;
						end
						wpsd_pkg::POS_CHANS: begin
							if (half16 != wpsd_pkg::CHANS_MONO) good_d = 1'b0;
						end
						wpsd_pkg::POS_RATE: begin
							if (fa_shift == wpsd_pkg::RATE_HALF) half_d = 1'b1;
							else if (fa_shift == wpsd_pkg::RATE_FULL) half_d = 1'b0;
							else good_d = 1'b0;
						end
						wpsd_pkg::POS_BITS: begin
							eight_d = (half16 == wpsd_pkg::BITS_EIGHT);
						end
						wpsd_pkg::POS_DATA: begin
							if (fa_shift != wpsd_pkg::TAG_DATA) good_d = 1'b0;
						end
						default: begin
						end
					endcase
					if (pos_q == wpsd_pkg::POS_LAST) begin
						res.cnt = 2'd1;
						if (!good_q) begin
							phase_d  = PH_DONE;
							res.kind = wpsd_pkg::KIND_REJECT;
						end else begin
							rem_d         = fa_shift;
							phase_d       = (fa_shift == 32'd0) ? PH_DONE : PH_DATA;
							pend_d        = 1'b0;
							res.kind      = wpsd_pkg::KIND_ACCEPT;
							res.half_rate = half_q;
							res.eight_bit = eight_q;
						end
					end
				end
				PH_DATA: begin
					rem_d = rem_dec;
					if (eod) phase_d = PH_DONE;
					if (eight_q) begin
						res.cnt    = half_q ? 2'd2 : 2'd1;
						res.sample = {data_byte, 8'h00} - wpsd_pkg::BIAS_8BIT;
						res.eod    = eod;
					end else if (!pend_q) begin
						if (eod) begin
							pend_d = 1'b0;
						end else begin
							hold_d = data_byte;
							pend_d = 1'b1;
						end
					end else begin
						res.cnt    = half_q ? 2'd2 : 2'd1;
						res.sample = {data_byte, hold_q};
						res.eod    = eod;
						pend_d     = 1'b0;
						hold_d     = '0;
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			good_q  <= 1'b1;
			fa_q    <= '0;
			eight_q <= 1'b0;
			half_q  <= 1'b0;
			rem_q   <= '0;
			hold_q  <= '0;
			pend_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			good_q  <= good_d;
			fa_q    <= fa_d;
			eight_q <= eight_d;
			half_q  <= half_d;
			rem_q   <= rem_d;
			hold_q  <= hold_d;
			pend_q  <= pend_d;
		end
	end

endmodule

FILE: sv/wav_pcm_stream_decoder_unit.sv
// Mono PCM WAV stream decoder. Feed the file one byte per transaction (cmd 0);
// cmd 1 restarts header parsing and gives no result. After the 44-byte header
// one result says accept (with half_rate and eight_bit) or reject; after an
// accept, the data chunk comes out as signed 16-bit samples, end_of_data marking
// the last one, and run_last marking the last result of each input byte. Bytes
// after the data chunk or after a reject are dropped until restart. A byte
// passes an input register and after it a single result register that drives
// the outputs. One byte is taken per cycle while out_stall is low, except that
// at 11025 Hz each sample goes out twice through the one result register, so
// an input byte that yields a sample holds that register for both copies.
module wav_pcm_stream_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [15:0] sample,
	output logic               half_rate,
	output logic               eight_bit,
	output logic               end_of_data,
	output logic               run_last
);

	logic           valid_s1;
	logic           cmd_s1;
	logic [7:0]     byte_s1;
	wpsd_pkg::res_t res;
	logic           advance;
	logic           take;
	logic           out_free;
	logic           load;

	logic           out_valid_q;
	logic           rep_q;
	logic           rep_eod_q;
	logic [1:0]     kind_q;
	logic [15:0]    sample_q;
	logic           half_q;
	logic           eight_q;
	logic           eod_q;
	logic           last_q;

	assign out_free = !out_valid_q || (!out_stall && !rep_q);
	assign advance  = out_free || (res.cnt == 2'd0);
	assign take     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign load     = take && (res.cnt != 2'd0);

	wpsd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rep_q       <= 1'b0;
			last_q      <= 1'b0;
			eod_q       <= 1'b0;
			rep_eod_q   <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			if (res.cnt == 2'd2) begin
				rep_q     <= 1'b1;
				last_q    <= 1'b0;
				eod_q     <= 1'b0;
				rep_eod_q <= res.eod;
			end else begin
				rep_q  <= 1'b0;
				last_q <= 1'b1;
				eod_q  <= res.eod;
			end
		end else if (out_valid_q && !out_stall) begin
			if (rep_q) begin
				rep_q  <= 1'b0;
				last_q <= 1'b1;
				eod_q  <= rep_eod_q;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= res.kind;
			sample_q <= res.sample;
			half_q   <= res.half_rate;
			eight_q  <= res.eight_bit;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign sample      = sample_q;
	assign half_rate   = half_q;
	assign eight_bit   = eight_q;
	assign end_of_data = eod_q;
	assign run_last    = last_q;

`ifndef SYNTHESIS
	a_rep_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> out_valid_q)
		else $error("repeat pending without a valid result");

	a_repeat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_q && out_valid_q && !out_stall) |=> (out_valid_q && last_q && !rep_q))
		else $error("repeated sample did not follow its first copy");

	a_first_copy_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> (!last_q && !eod_q))
		else $error("first copy of a repeated sample marked last");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with free result register");
`endif

endmodule

FILE: tb/sv/wav_pcm_stream_decoder_unit_test.sv
`timescale 1ns / 100ps

module wav_pcm_stream_decoder_unit_test;

	localparam int HDR_LEN = 44;
	localparam int ITEM_GOAL = 1750;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	localparam logic [5:0] AT_RIFF  = 6'd3;
	localparam logic [5:0] AT_WAVE  = 6'd11;
	localparam logic [5:0] AT_FMT   = 6'd15;
	localparam logic [5:0] AT_FTAG  = 6'd21;
	localparam logic [5:0] AT_CHANS = 6'd23;
	localparam logic [5:0] AT_RATE  = 6'd27;
	localparam logic [5:0] AT_BITS  = 6'd35;
	localparam logic [5:0] AT_DATA  = 6'd39;
	localparam logic [5:0] AT_LAST  = 6'd43;

	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;
	localparam logic [31:0] HZ_FULL = 32'd22050;
	localparam logic [31:0] HZ_HALF = 32'd11025;
	localparam logic [15:0] PCM_CODE = 16'd1;
	localparam logic [15:0] MONO     = 16'd1;
	localparam logic [15:0] BITS_8   = 16'd8;
	localparam logic [15:0] OFFSET_8 = 16'h7F00;

	typedef enum logic [1:0] {ST_HEADER, ST_DATA, ST_DONE} dec_stage_t;
	typedef enum int {BREAK_NONE, BREAK_RIFF, BREAK_WAVE, BREAK_FMT, BREAK_DATA} tag_break_t;

	typedef struct packed {
		wpsd_pkg::kind_t kind;
		logic [15:0]     sample;
		logic            half_rate;
		logic            eight_bit;
		logic            eod;
		logic            last;
	} wav_out_t;

	typedef struct {
		logic [31:0]     rate;
		logic [15:0]     fmt;
		logic [15:0]     chans;
		logic [15:0]     bits;
		tag_break_t      brk;
		logic [31:0]     size;
		int              n_after;
		logic [31:0]     payload;
		int              cut_at;
		bit              typed;
		wpsd_pkg::kind_t v_kind;
		bit              v_half;
		bit              v_eight;
	} file_case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic signed [15:0] sample;
	logic half_rate;
	logic eight_bit;
	logic end_of_data;
	logic run_last;

	wav_out_t wav_out_q[$];
	wav_out_t head_result;
	file_case_t dir_cases [20];
	int errors = 0;
	int live_items = 0;
	int quiet_cycles = 0;
	int in_idle_pct = 17;
	int out_idle_pct = 79;
	int hold_left = 0;
	bit hold_pending = 1'b0;
	bit pressured = 1'b0;

	logic [5:0]  hdr_pos;
	dec_stage_t  stage;
	logic        hdr_ok;
	logic [31:0] asm_word;
	logic        pcm8;
	logic        slow_rate;
	logic [31:0] left;
	logic [7:0]  lo_byte;
	logic        lo_pend;

	wav_pcm_stream_decoder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.sample(sample),
		.half_rate(half_rate),
		.eight_bit(eight_bit),
		.end_of_data(end_of_data),
		.run_last(run_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_decoder();
		hdr_pos = '0;
		stage = ST_HEADER;
		hdr_ok = 1'b1;
		asm_word = '0;
		pcm8 = 1'b0;
		slow_rate = 1'b0;
		left = '0;
		lo_byte = '0;
		lo_pend = 1'b0;
	endfunction

	// Advance the decoder by one transaction; return 1 when the byte is dropped.
	function automatic bit decode_byte(input logic c, input logic [7:0] b);
		logic [5:0] at;
		logic [15:0] smp;
		logic last_byte;
		wav_out_t r;
		if (c) begin
			clear_decoder();
			return 1'b0;
		end
		r = '0;
		case (stage)
			ST_HEADER: begin
				at = hdr_pos;
				asm_word = {b, asm_word[31:8]};
				hdr_pos = at + 6'd1;
				case (at)
					AT_RIFF: if (asm_word != ID_RIFF) hdr_ok = 1'b0;
					AT_WAVE: if (asm_word != ID_WAVE) hdr_ok = 1'b0;
					AT_FMT: if (asm_word != ID_FMT) hdr_ok = 1'b0;
					AT_FTAG: if (asm_word[31:16] != PCM_CODE) hdr_ok = 1'b0;
					AT_CHANS: if (asm_word[31:16] != MONO) hdr_ok = 1'b0;
					AT_RATE: begin
						if (asm_word == HZ_HALF) slow_rate = 1'b1;
						else if (asm_word == HZ_FULL) slow_rate = 1'b0;
						else hdr_ok = 1'b0;
					end
					AT_BITS: pcm8 = (asm_word[31:16] == BITS_8);
					AT_DATA: if (asm_word != ID_DATA) hdr_ok = 1'b0;
					default: ;
				endcase
				if (at == AT_LAST) begin
					r.last = 1'b1;
					if (!hdr_ok) begin
						stage = ST_DONE;
						r.kind = wpsd_pkg::KIND_REJECT;
					end else begin
						left = asm_word;
						stage = (left == 0) ? ST_DONE : ST_DATA;
						lo_pend = 1'b0;
						r.kind = wpsd_pkg::KIND_ACCEPT;
						r.half_rate = slow_rate;
						r.eight_bit = pcm8;
					end
					wav_out_q.push_back(r);
				end
				return 1'b0;
			end
			ST_DATA: begin
				left = left - 32'd1;
				last_byte = (left == 0);
				if (last_byte) stage = ST_DONE;
				if (pcm8) begin
					smp = {b, 8'h00} - OFFSET_8;
				end else if (!lo_pend) begin
					if (!last_byte) begin
						lo_byte = b;
						lo_pend = 1'b1;
					end
					return 1'b0;
				end else begin
					smp = {b, lo_byte};
					lo_pend = 1'b0;
					lo_byte = '0;
				end
				r.kind = wpsd_pkg::KIND_SAMPLE;
				r.sample = smp;
				if (slow_rate) wav_out_q.push_back(r);
				r.eod = last_byte;
				r.last = 1'b1;
				wav_out_q.push_back(r);
				return 1'b0;
			end
			default: return 1'b1;
		endcase
	endfunction

	task automatic send_item(input logic c, input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		if (!decode_byte(c, b)) live_items++;
	endtask

	task automatic send_file(input file_case_t fc);
		logic [7:0] hdr [HDR_LEN];
		logic [31:0] ids [4];
		wav_out_t verdict;
		int i;
		ids = '{ID_RIFF, ID_WAVE, ID_FMT, ID_DATA};
		if (fc.brk != BREAK_NONE) ids[int'(fc.brk) - 1] ^= 32'd1 << $urandom_range(31);
		for (i = 0; i < 4; i++) begin
			hdr[i] = ids[0][8*i +: 8];
			hdr[4 + i] = 8'($urandom);
			hdr[8 + i] = ids[1][8*i +: 8];
			hdr[12 + i] = ids[2][8*i +: 8];
			hdr[16 + i] = 8'($urandom);
			hdr[24 + i] = fc.rate[8*i +: 8];
			hdr[28 + i] = 8'($urandom);
			hdr[36 + i] = ids[3][8*i +: 8];
			hdr[40 + i] = fc.size[8*i +: 8];
		end
		for (i = 0; i < 2; i++) begin
			hdr[20 + i] = fc.fmt[8*i +: 8];
			hdr[22 + i] = fc.chans[8*i +: 8];
			hdr[32 + i] = 8'($urandom);
			hdr[34 + i] = fc.bits[8*i +: 8];
		end
		send_item(1'b1, 8'($urandom));
		if (fc.cut_at >= 0) begin
			for (i = 0; i < fc.cut_at; i++) send_item(1'b0, hdr[i]);
			send_item(1'b1, 8'($urandom));
		end
		for (i = 0; i < HDR_LEN; i++) send_item(1'b0, hdr[i]);
		if (fc.typed) begin
			verdict = '0;
			verdict.kind = fc.v_kind;
			verdict.half_rate = fc.v_half;
			verdict.eight_bit = fc.v_eight;
			verdict.last = 1'b1;
			void'(wav_out_q.pop_back());
			wav_out_q.push_back(verdict);
		end
		for (i = 0; i < fc.n_after; i++)
			send_item(1'b0, (i < 4) ? fc.payload[8*i +: 8] : 8'($urandom));
	endtask

	task automatic send_random_file();
		file_case_t fc;
		int pick;
		int k;
		pick = $urandom_range(99);
		if (pick >= 88) begin
			send_item(1'b1, 8'($urandom));
			repeat ($urandom_range(60, 1)) send_item($urandom_range(15) == 0, 8'($urandom));
			return;
		end
		fc.rate = $urandom_range(1) ? HZ_HALF : HZ_FULL;
		fc.fmt = PCM_CODE;
		fc.chans = MONO;
		fc.bits = $urandom_range(1) ? BITS_8 : 16'd16;
		if ($urandom_range(9) == 0) fc.bits = 16'($urandom);
		fc.brk = BREAK_NONE;
		fc.size = $urandom_range(20);
		if ($urandom_range(7) == 0) fc.size = $urandom;
		fc.n_after = (fc.size > 24) ? $urandom_range(24, 1) : int'(fc.size) + $urandom_range(3);
		fc.payload = $urandom;
		fc.cut_at = ($urandom_range(9) == 0) ? $urandom_range(HDR_LEN - 1) : -1;
		fc.typed = 1'b0;
		fc.v_kind = wpsd_pkg::KIND_SAMPLE;
		fc.v_half = 1'b0;
		fc.v_eight = 1'b0;
		if (pick >= 70) begin
			k = $urandom_range(31);
			case ($urandom_range(6))
				0: fc.fmt ^= 16'd1 << (k % 16);
				1: fc.chans ^= 16'd1 << (k % 16);
				2: fc.rate ^= 32'd1 << k;
				default: fc.brk = tag_break_t'($urandom_range(BREAK_DATA, BREAK_RIFF));
			endcase
		end
		send_file(fc);
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (wav_out_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				head_result = wav_out_q.pop_front();
				check_field("kind", 16'(head_result.kind), 16'(kind));
				check_field("sample", head_result.sample, sample);
				check_field("half_rate", 16'(head_result.half_rate), 16'(half_rate));
				check_field("eight_bit", 16'(head_result.eight_bit), 16'(eight_bit));
				check_field("end_of_data", 16'(head_result.eod), 16'(end_of_data));
				check_field("run_last", 16'(head_result.last), 16'(run_last));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_pending) begin
			hold_pending = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		// rate, fmt, chans, bits, broken tag, data size, bytes after header, first data
		// bytes, restart point, typed verdict, kind, half_rate, eight_bit
		dir_cases = '{
			'{HZ_FULL, PCM_CODE, MONO, 16'd16, BREAK_NONE, 32'd4, 7, 32'h8000_7FFF, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b0, 1'b0},
			'{HZ_HALF, PCM_CODE, MONO, 16'd16, BREAK_NONE, 32'd4, 6, 32'hFFFF_0000, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b1, 1'b0},
			'{HZ_FULL, PCM_CODE, MONO, BITS_8, BREAK_NONE, 32'd4, 6, 32'h7F80_FF00, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b0, 1'b1},
			'{HZ_HALF, PCM_CODE, MONO, BITS_8, BREAK_NONE, 32'd3, 5, 32'h0001_FF80, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b1, 1'b1},
			'{HZ_FULL, PCM_CODE, MONO, 16'd16, BREAK_NONE, 32'd3, 5, 32'h0012_3456, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b0, 1'b0},
			'{HZ_HALF, PCM_CODE, MONO, 16'd16, BREAK_NONE, 32'd5, 6, 32'hA5C3_5A3C, -1,
				1'b0, wpsd_pkg::KIND_SAMPLE, 1'b0, 1'b0},
			'{HZ_FULL, PCM_CODE, MONO, 16'd16, BREAK_NONE, 32'd0, 3, 32'hDEAD_BEEF, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b0, 1'b0},
			'{HZ_FULL, PCM_CODE, MONO, 16'd24, BREAK_NONE, 32'd2, 3, 32'h0000_8001, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b0, 1'b0},
			'{HZ_HALF, PCM_CODE, MONO, 16'd0, BREAK_NONE, 32'd2, 2, 32'h1234_5678, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b1, 1'b0},
			'{HZ_FULL, PCM_CODE, MONO, 16'hFFFF, BREAK_NONE, 32'd2, 2, 32'h0000_C3A5, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b0, 1'b0},
			'{HZ_FULL, PCM_CODE, MONO, 16'd16, BREAK_RIFF, 32'd4, 4, 32'h1111_2222, -1,
				1'b1, wpsd_pkg::KIND_REJECT, 1'b0, 1'b0},
			'{HZ_FULL, PCM_CODE, MONO, BITS_8, BREAK_WAVE, 32'd4, 4, 32'h3333_4444, -1,
				1'b1, wpsd_pkg::KIND_REJECT, 1'b0, 1'b0},
			'{HZ_HALF, PCM_CODE, MONO, 16'd16, BREAK_FMT, 32'd4, 4, 32'h5555_6666, -1,
				1'b1, wpsd_pkg::KIND_REJECT, 1'b0, 1'b0},
			'{HZ_FULL, PCM_CODE, MONO, 16'd16, BREAK_DATA, 32'd4, 4, 32'h7777_8888, 43,
				1'b1, wpsd_pkg::KIND_REJECT, 1'b0, 1'b0},
			'{HZ_FULL, 16'd3, MONO, 16'd16, BREAK_NONE, 32'd4, 4, 32'h9999_AAAA, -1,
				1'b1, wpsd_pkg::KIND_REJECT, 1'b0, 1'b0},
			'{HZ_FULL, PCM_CODE, 16'd2, 16'd16, BREAK_NONE, 32'd4, 4, 32'hBBBB_CCCC, -1,
				1'b1, wpsd_pkg::KIND_REJECT, 1'b0, 1'b0},
			'{32'd44100, PCM_CODE, MONO, 16'd16, BREAK_NONE, 32'd4, 4, 32'hDDDD_EEEE, -1,
				1'b1, wpsd_pkg::KIND_REJECT, 1'b0, 1'b0},
			'{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, BITS_8, BREAK_NONE, 32'd4, 4, 32'hFFFF_FFFF, 0,
				1'b1, wpsd_pkg::KIND_REJECT, 1'b0, 1'b0},
			'{HZ_HALF, PCM_CODE, MONO, 16'd16, BREAK_NONE, 32'hFFFF_FFFF, 6, 32'h0102_0304, -1,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b1, 1'b0},
			'{HZ_FULL, PCM_CODE, MONO, BITS_8, BREAK_NONE, 32'd4, 4, 32'h0080_FF7F, 20,
				1'b1, wpsd_pkg::KIND_ACCEPT, 1'b0, 1'b1}
		};
		clear_decoder();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_cases[n]) send_file(dir_cases[n]);
		while (live_items < ITEM_GOAL) begin
			if (live_items >= 2 * ITEM_GOAL / 3) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
				if (!pressured) begin
					pressured = 1'b1;
					hold_pending = 1'b1;
				end
			end else if (live_items >= ITEM_GOAL / 3) begin
				in_idle_pct = 79;
				out_idle_pct = 17;
			end
			send_random_file();
		end
		in_valid <= 1'b0;
		while (wav_out_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
